>>> hw/rtl/psia_pkg.sv
`timescale 1ns / 1ps

package psia_pkg;

    // Operand and result geometry.
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 4;
    localparam int BYTE_W      = 8;
    localparam int HALF_W      = 2 * WORD_W;
    localparam int KIND_W      = 5;

    // Shuffle index byte: bit 7 zeroes the byte, the low four bits pick a byte.
    localparam int IDX_ZERO_BIT = 7;
    localparam int IDX_SEL_W    = 4;

    // Operation codes.
    typedef enum logic [KIND_W-1:0] {
        K_XOR   = 5'd0,
        K_AND   = 5'd1,
        K_OR    = 5'd2,
        K_ANDN  = 5'd3,
        K_ADDB  = 5'd4,
        K_SUBB  = 5'd5,
        K_ADDW  = 5'd6,
        K_SUBW  = 5'd7,
        K_ADDD  = 5'd8,
        K_SUBD  = 5'd9,
        K_ADDQ  = 5'd10,
        K_SUBQ  = 5'd11,
        K_MULLW = 5'd12,
        K_SLLW  = 5'd13,
        K_SLLD  = 5'd14,
        K_SLLQ  = 5'd15,
        K_SRLW  = 5'd16,
        K_SRLD  = 5'd17,
        K_SRLQ  = 5'd18,
        K_SRAW  = 5'd19,
        K_SRAD  = 5'd20,
        K_SHUF  = 5'd21
    } t_kind;

    localparam t_kind KIND_LAST = K_SHUF;

    // Control shared by every lane for one request.
    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  shift_count;
    } t_lane_ctrl;

endpackage

>>> hw/rtl/packed_simd_integer_alu.sv
`timescale 1ns / 1ps
// Packed-integer vector ALU on 128-bit or 256-bit operands.
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while a held result is not stalled; four
// 64-bit lanes compute in parallel and the output register holds their words.
// Reset (synchronous, active low) clears only the result valid flag.

module packed_simd_integer_alu
    import psia_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic                i_wide_mode,
    input  logic [WORD_W-1:0]   i_lhs_word0,
    input  logic [WORD_W-1:0]   i_lhs_word1,
    input  logic [WORD_W-1:0]   i_lhs_word2,
    input  logic [WORD_W-1:0]   i_lhs_word3,
    input  logic [WORD_W-1:0]   i_rhs_word0,
    input  logic [WORD_W-1:0]   i_rhs_word1,
    input  logic [WORD_W-1:0]   i_rhs_word2,
    input  logic [WORD_W-1:0]   i_rhs_word3,
    input  logic [WORD_W-1:0]   i_shift_count,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [WORD_W-1:0]   o_res_word0,
    output logic [WORD_W-1:0]   o_res_word1,
    output logic [WORD_W-1:0]   o_res_word2,
    output logic [WORD_W-1:0]   o_res_word3
);

    logic [WORD_W-1:0] lhs_w   [NUM_WORDS];
    logic [WORD_W-1:0] rhs_w   [NUM_WORDS];
    logic [WORD_W-1:0] lane_res[NUM_WORDS];
    logic [WORD_W-1:0] n_res   [NUM_WORDS];
    logic [WORD_W-1:0] r_res   [NUM_WORDS];
    logic              r_valid;
    logic              in_accept;
    t_lane_ctrl        ctrl;

    assign lhs_w[0] = i_lhs_word0;
    assign lhs_w[1] = i_lhs_word1;
    assign lhs_w[2] = i_lhs_word2;
    assign lhs_w[3] = i_lhs_word3;
    assign rhs_w[0] = i_rhs_word0;
    assign rhs_w[1] = i_rhs_word1;
    assign rhs_w[2] = i_rhs_word2;
    assign rhs_w[3] = i_rhs_word3;

    assign ctrl.kind        = t_kind'(i_kind);
    assign ctrl.shift_count = i_shift_count;

    // One lane per 64-bit word; the shuffle table is the word's 16-byte half.
    for (genvar w = 0; w < NUM_WORDS; w++) begin : g_lane
        psia_lane u_lane (
            .i_ctrl  (ctrl),
            .i_lhs   (lhs_w[w]),
            .i_rhs   (rhs_w[w]),
            .i_table ({lhs_w[2*(w/2)+1], lhs_w[2*(w/2)]}),
            .o_res   (lane_res[w])
        );
    end

    // Merge: the upper half of the result is zero in narrow mode.
    always_comb begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            n_res[w] = (w >= NUM_WORDS / 2 && !i_wide_mode) ? '0 : lane_res[w];
        end
    end

    // Output register; a new request is taken unless a held result is stalled.
    assign o_stall   = r_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (in_accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid     = r_valid;
    assign o_res_word0 = r_res[0];
    assign o_res_word1 = r_res[1];
    assign o_res_word2 = r_res[2];
    assign o_res_word3 = r_res[3];

`ifndef SYNTH
    // An accepted request always shows up as a result in the next cycle.
    a_accept_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted request did not produce a result");

    // Narrow-mode requests leave the upper result words at zero.
    a_narrow_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_wide_mode) |=>
            (o_res_word2 == '0 && o_res_word3 == '0))
        else $error("upper words not zero in narrow mode");

    // Undefined operation codes give an all-zero result.
    a_unused_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_kind > KIND_W'(KIND_LAST))) |=>
            (o_res_word0 == '0 && o_res_word1 == '0 &&
             o_res_word2 == '0 && o_res_word3 == '0))
        else $error("undefined operation code gave a nonzero result");
`endif

endmodule

>>> hw/rtl/psia_lane.sv
`timescale 1ns / 1ps

module psia_lane
    import psia_pkg::*;
(
    input  t_lane_ctrl          i_ctrl,
    input  logic [WORD_W-1:0]   i_lhs,
    input  logic [WORD_W-1:0]   i_rhs,
    input  logic [HALF_W-1:0]   i_table,
    output logic [WORD_W-1:0]   o_res
);

    logic [WORD_W-1:0] addsub_res;
    logic [WORD_W-1:0] mul_res;
    logic [WORD_W-1:0] sll16, srl16, sra16;
    logic [WORD_W-1:0] sll32, srl32, sra32;
    logic [WORD_W-1:0] sll64, srl64;
    logic [WORD_W-1:0] shuf_res;

    // Add and subtract on a byte-sliced carry chain; the carry is cut at lane starts.
    always_comb begin
        logic       sub;
        logic [2:0] byte_mask;
        logic       carry;
        logic       cin;
        logic [8:0] sum9;
        sub       = 1'b0;
        byte_mask = 3'd0;
        carry     = 1'b0;
        case (i_ctrl.kind)
            K_ADDB: begin byte_mask = 3'd0; sub = 1'b0; end
            K_SUBB: begin byte_mask = 3'd0; sub = 1'b1; end
            K_ADDW: begin byte_mask = 3'd1; sub = 1'b0; end
            K_SUBW: begin byte_mask = 3'd1; sub = 1'b1; end
            K_ADDD: begin byte_mask = 3'd3; sub = 1'b0; end
            K_SUBD: begin byte_mask = 3'd3; sub = 1'b1; end
            K_ADDQ: begin byte_mask = 3'd7; sub = 1'b0; end
            K_SUBQ: begin byte_mask = 3'd7; sub = 1'b1; end
            default: begin byte_mask = 3'd0; sub = 1'b0; end
        endcase
        for (int j = 0; j < WORD_W / BYTE_W; j++) begin
            cin  = ((3'(j) & byte_mask) == 3'd0) ? sub : carry;
            sum9 = {1'b0, i_lhs[BYTE_W*j +: BYTE_W]}
                 + {1'b0, i_rhs[BYTE_W*j +: BYTE_W] ^ {BYTE_W{sub}}}
                 + {8'd0, cin};
            addsub_res[BYTE_W*j +: BYTE_W] = sum9[BYTE_W-1:0];
            carry = sum9[BYTE_W];
        end
    end

    // Four 16x16 multipliers, low product half kept.
    always_comb begin
        logic [31:0] prod;
        for (int m = 0; m < WORD_W / 16; m++) begin
            prod = {16'd0, i_lhs[16*m +: 16]} * {16'd0, i_rhs[16*m +: 16]};
            mul_res[16*m +: 16] = prod[15:0];
        end
    end

    // Lane shifters; an arithmetic shift past the lane width shifts by width-1.
    always_comb begin
        logic        sat16, sat32, sat64;
        logic [3:0]  c16;
        logic [4:0]  c32;
        logic [5:0]  c64;
        logic [15:0] x16;
        logic [31:0] x32;
        sat16 = |i_ctrl.shift_count[WORD_W-1:4];
        sat32 = |i_ctrl.shift_count[WORD_W-1:5];
        sat64 = |i_ctrl.shift_count[WORD_W-1:6];
        c16   = i_ctrl.shift_count[3:0];
        c32   = i_ctrl.shift_count[4:0];
        c64   = i_ctrl.shift_count[5:0];
        for (int m = 0; m < WORD_W / 16; m++) begin
            x16 = i_lhs[16*m +: 16];
            sll16[16*m +: 16] = sat16 ? 16'd0 : (x16 << c16);
            srl16[16*m +: 16] = sat16 ? 16'd0 : (x16 >> c16);
            sra16[16*m +: 16] = 16'($signed(x16) >>> (sat16 ? 4'd15 : c16));
        end
        for (int m = 0; m < WORD_W / 32; m++) begin
            x32 = i_lhs[32*m +: 32];
            sll32[32*m +: 32] = sat32 ? 32'd0 : (x32 << c32);
            srl32[32*m +: 32] = sat32 ? 32'd0 : (x32 >> c32);
            sra32[32*m +: 32] = 32'($signed(x32) >>> (sat32 ? 5'd31 : c32));
        end
        sll64 = sat64 ? '0 : (i_lhs << c64);
        srl64 = sat64 ? '0 : (i_lhs >> c64);
    end

    // Byte shuffle from the 16-byte half that this word belongs to.
    always_comb begin
        logic [BYTE_W-1:0]    ix;
        logic [IDX_SEL_W-1:0] sel;
        for (int j = 0; j < WORD_W / BYTE_W; j++) begin
            ix  = i_rhs[BYTE_W*j +: BYTE_W];
            sel = ix[IDX_SEL_W-1:0];
            shuf_res[BYTE_W*j +: BYTE_W] = ix[IDX_ZERO_BIT] ? '0
                                         : i_table[BYTE_W*sel +: BYTE_W];
        end
    end

    // Pick the unit that the operation code names.
    always_comb begin
        case (i_ctrl.kind)
            K_XOR:   o_res = i_lhs ^ i_rhs;
            K_AND:   o_res = i_lhs & i_rhs;
            K_OR:    o_res = i_lhs | i_rhs;
            K_ANDN:  o_res = ~i_lhs & i_rhs;
            K_ADDB, K_SUBB, K_ADDW, K_SUBW,
            K_ADDD, K_SUBD, K_ADDQ, K_SUBQ: o_res = addsub_res;
            K_MULLW: o_res = mul_res;
            K_SLLW:  o_res = sll16;
            K_SLLD:  o_res = sll32;
            K_SLLQ:  o_res = sll64;
            K_SRLW:  o_res = srl16;
            K_SRLD:  o_res = srl32;
            K_SRLQ:  o_res = srl64;
            K_SRAW:  o_res = sra16;
            K_SRAD:  o_res = sra32;
            K_SHUF:  o_res = shuf_res;
            default: o_res = '0;
        endcase
    end

endmodule
